### hw/rtl/hsp_pkg.sv
// shared types and frame constants for the paged serial exchange master
package hsp_pkg;

    // frame characters
    localparam logic [7:0] CH_STX     = 8'h02;
    localparam logic [7:0] CH_ETX     = 8'h03;
    localparam logic [7:0] CH_W       = 8'h57;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_STATION = 8'h00;
    localparam logic [7:0] CH_RESP_OK = 8'h00;
    localparam logic [7:0] ADDR_HI_WR = 8'h01;
    localparam logic [7:0] ADDR_HI_RD = 8'h02;
    localparam logic [7:0] RD_REQ_LEN = 8'h05;
    localparam logic [3:0] MAX_RETRY  = 4'd10;

    // result kinds
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_HOST = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // memory write operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SEND_WR,
        OP_SEND_CLR,
        OP_RPL_WR,
        OP_READ_WR
    } op_t;

    // byte source for output and checking
    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_SEND,
        SRC_READ,
        SRC_RPL,
        SRC_SUM
    } src_t;

    // controller to datapath commands
    typedef struct packed {
        op_t        op;
        logic [5:0] img_addr;
        logic [5:0] rpl_addr;
        src_t       src;
        logic [7:0] kbyte;
        logic       sum_clr;
        logic       sum_add;
        logic       chk_clr;
        logic       chk_eq;
        logic       chk_sum;
        logic       out_load;
        logic [1:0] kind;
        logic       out_end;
        logic       out_link;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic chk_ok;
    } sts_t;

endpackage

### hw/rtl/hsp_dp.sv
// datapath: images, reply buffer, checksum, checker and output register
module hsp_dp import hsp_pkg::*; #(
    parameter int PAGE_BYTES = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_out_kind,
    output logic [7:0] m_out_byte,
    output logic       m_frame_end,
    output logic       m_link_up
);

    localparam int RPL_DEPTH = PAGE_BYTES + 8;
    localparam int RAW       = $clog2(RPL_DEPTH);

    logic [7:0]  send_mem [64];
    logic [7:0]  read_mem [64];
    logic [7:0]  rpl_mem  [RPL_DEPTH];
    logic [63:0] send_vld_reg;
    logic [63:0] read_vld_reg;
    logic [7:0]  send_rd_reg;
    logic [7:0]  read_rd_reg;
    logic [7:0]  rpl_rd_reg;
    logic        send_vr_reg;
    logic        read_vr_reg;
    logic [7:0]  sum_reg, sum_next;
    logic        ok_reg, ok_next;
    logic        valid_reg, valid_next;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;
    logic        link_reg;
    logic [7:0]  val;

    // memory writes and registered reads
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_SEND_WR) begin
            send_mem[cmd.img_addr] <= s_data_byte;
        end
        if (cmd.op == OP_READ_WR) begin
            read_mem[cmd.img_addr] <= rpl_rd_reg;
        end
        if (cmd.op == OP_RPL_WR) begin
            rpl_mem[cmd.rpl_addr[RAW-1:0]] <= s_data_byte;
        end
        send_rd_reg <= send_mem[cmd.img_addr];
        read_rd_reg <= read_mem[cmd.img_addr];
        rpl_rd_reg  <= rpl_mem[cmd.rpl_addr[RAW-1:0]];
        send_vr_reg <= send_vld_reg[cmd.img_addr];
        read_vr_reg <= read_vld_reg[cmd.img_addr];
    end

    // image valid bits, an entry not valid reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_vld_reg <= '0;
            read_vld_reg <= '0;
        end else begin
            if (cmd.op == OP_SEND_CLR) begin
                send_vld_reg <= '0;
            end
            if (cmd.op == OP_SEND_WR) begin
                send_vld_reg[cmd.img_addr] <= 1'b1;
            end
            if (cmd.op == OP_READ_WR) begin
                read_vld_reg[cmd.img_addr] <= 1'b1;
            end
        end
    end

    // byte select
    always_comb begin
        case (cmd.src)
            SRC_CONST: val = cmd.kbyte;
            SRC_SEND:  val = send_vr_reg ? send_rd_reg : 8'h00;
            SRC_READ:  val = read_vr_reg ? read_rd_reg : 8'h00;
            SRC_RPL:   val = rpl_rd_reg;
            SRC_SUM:   val = sum_reg;
            default:   val = cmd.kbyte;
        endcase
    end

    // checksum and reply checker
    always_comb begin
        sum_next = cmd.sum_clr ? 8'h00 : sum_reg;
        if (cmd.sum_add) begin
            sum_next = sum_next + val;
        end
        ok_next = cmd.chk_clr ? 1'b1 : ok_reg;
        if (cmd.chk_eq && val != cmd.kbyte) begin
            ok_next = 1'b0;
        end
        if (cmd.chk_sum && val != sum_reg) begin
            ok_next = 1'b0;
        end
    end

    // output register
    assign valid_next   = cmd.out_load ? 1'b1 : (valid_reg && !m_ready);
    assign sts.out_free = !valid_reg || m_ready;
    assign sts.chk_ok   = ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sum_reg   <= 8'h00;
            ok_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sum_reg   <= sum_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            kind_reg <= cmd.kind;
            byte_reg <= val;
            end_reg  <= cmd.out_end;
            link_reg <= cmd.out_link;
        end
    end

    assign m_valid     = valid_reg;
    assign m_out_kind  = kind_reg;
    assign m_out_byte  = byte_reg;
    assign m_frame_end = end_reg;
    assign m_link_up   = link_reg;

endmodule

### hw/rtl/hsp_ctrl.sv
// controller: exchange sequencing, frame walk, reply judging and retries
module hsp_ctrl import hsp_pkg::*; #(
    parameter int PAGE_BYTES = 32,
    parameter int SEND_PAGES = 2,
    parameter int READ_PAGES = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [5:0]  s_image_address,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_gap_ticks,
    output cmd_t        cmd,
    input  sts_t        sts
);

    localparam int MAX_PAGES = (SEND_PAGES > READ_PAGES) ? SEND_PAGES : READ_PAGES;
    localparam int PIW       = $clog2(MAX_PAGES + 1);
    localparam int CW        = $clog2(PAGE_BYTES + 9);
    localparam int KW        = $clog2(PAGE_BYTES + 10);
    localparam int BW        = $clog2(MAX_PAGES * PAGE_BYTES + 1);
    localparam int SEND_SPAN = PAGE_BYTES * SEND_PAGES;
    localparam int WR_LEN    = PAGE_BYTES + 10;
    localparam int RD_LEN    = 10;
    localparam int RPL_LEN   = PAGE_BYTES + 8;
    localparam int ACK_LIMIT = 10;
    localparam logic [7:0] WR_LEN_BYTE  = 8'(PAGE_BYTES + 5);
    localparam logic [7:0] RPL_LEN_BYTE = 8'(PAGE_BYTES + 3);
    localparam logic [7:0] WORDS_BYTE   = 8'(PAGE_BYTES / 2);

    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_RX    = 3'd1,
        REQ_DRAIN = 3'd2,
        REQ_CONT  = 3'd3,
        REQ_HWR   = 3'd4,
        REQ_HRD   = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DRAIN,
        PH_ACK,
        PH_REPLY
    } phase_t;

    typedef enum logic [3:0] {
        ST_WAIT,
        ST_EM_RD,
        ST_EM_PUT,
        ST_J_RD,
        ST_J_CK,
        ST_J_END,
        ST_CP_RD,
        ST_CP_WR,
        ST_HRD,
        ST_DONE
    } state_t;

    state_t         state_reg, state_next;
    phase_t         phase_reg, phase_next;
    logic [PIW-1:0] page_reg, page_next;
    logic [CW-1:0]  rcnt_reg, rcnt_next;
    logic [15:0]    gap_reg, gap_next;
    logic [3:0]     retry_reg, retry_next;
    logic           link_reg, link_next;
    logic [KW-1:0]  k_reg, k_next;
    logic           wfrm_reg, wfrm_next;
    logic           jack_reg, jack_next;
    logic [5:0]     haddr_reg, haddr_next;
    logic [15:0]    gap_ticks_reg, gap_ticks_next;

    logic [BW-1:0]  page_base;
    logic [PIW-1:0] pg_inc;
    logic [7:0]     addr_lo;
    logic [KW-1:0]  fr_len;
    logic           em_last;
    logic           em_data;
    logic [7:0]     em_byte;
    logic [5:0]     emit_idx;
    logic [5:0]     copy_idx;
    logic [15:0]    gap_inc;
    logic [CW-1:0]  rx_limit;
    logic           fail;
    logic           start_wr;
    logic           start_rd;

    // expected write acknowledgement
    function automatic logic [7:0] ack_byte(input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = CH_STX;
            3'd1:    b = CH_STATION;
            3'd2:    b = 8'h03;
            3'd3:    b = CH_W;
            3'd4:    b = CH_W;
            3'd5:    b = 8'h00;
            3'd6:    b = 8'h03;
            3'd7:    b = 8'hB4;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // page addressing and frame bytes
    always_comb begin
        page_base = BW'(page_reg) * BW'(PAGE_BYTES);
        pg_inc    = page_reg + 1'b1;
        addr_lo   = 8'(page_base >> 1);
        fr_len    = wfrm_reg ? KW'(WR_LEN) : KW'(RD_LEN);
        em_last   = (k_reg == fr_len - 1'b1);
        em_data   = wfrm_reg && (k_reg >= KW'(8)) && (k_reg < KW'(8 + PAGE_BYTES));
        emit_idx  = 6'(page_base + BW'(k_reg - KW'(8)));
        copy_idx  = 6'(page_base + BW'(k_reg));
        case (int'(k_reg))
            0:       em_byte = CH_STX;
            1:       em_byte = CH_STATION;
            2:       em_byte = wfrm_reg ? WR_LEN_BYTE : RD_REQ_LEN;
            3:       em_byte = wfrm_reg ? CH_W : CH_R;
            4:       em_byte = CH_W;
            5:       em_byte = addr_lo;
            6:       em_byte = wfrm_reg ? ADDR_HI_WR : ADDR_HI_RD;
            7:       em_byte = WORDS_BYTE;
            default: em_byte = CH_ETX;
        endcase
    end

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        page_next      = page_reg;
        rcnt_next      = rcnt_reg;
        gap_next       = gap_reg;
        retry_next     = retry_reg;
        link_next      = link_reg;
        k_next         = k_reg;
        wfrm_next      = wfrm_reg;
        jack_next      = jack_reg;
        haddr_next     = haddr_reg;
        gap_ticks_next = cfg_valid ? cfg_gap_ticks : gap_ticks_reg;
        fail           = 1'b0;
        start_wr       = 1'b0;
        start_rd       = 1'b0;
        gap_inc        = (gap_reg == 16'hFFFF) ? gap_reg : gap_reg + 16'd1;
        rx_limit       = (phase_reg == PH_ACK) ? CW'(ACK_LIMIT) : CW'(RPL_LEN);

        cmd          = '0;
        cmd.op       = OP_NONE;
        cmd.src      = SRC_CONST;
        cmd.kind     = KIND_TX;
        cmd.out_link = link_reg;

        // address selection
        case (state_reg)
            ST_WAIT:            cmd.img_addr = s_image_address;
            ST_HRD:             cmd.img_addr = haddr_reg;
            ST_CP_RD, ST_CP_WR: cmd.img_addr = copy_idx;
            default:            cmd.img_addr = emit_idx;
        endcase
        case (state_reg)
            ST_WAIT:                    cmd.rpl_addr = 6'(rcnt_reg);
            ST_CP_RD, ST_CP_WR:         cmd.rpl_addr = 6'(k_reg + KW'(6));
            default:                    cmd.rpl_addr = 6'(k_reg);
        endcase

        case (state_reg)
            // take one request
            ST_WAIT: begin
                if (s_valid) begin
                    case (req_t'(s_req_type))
                        REQ_TICK: begin
                            if (phase_reg == PH_ACK || phase_reg == PH_REPLY) begin
                                gap_next = gap_inc;
                                if (gap_inc >= gap_ticks_reg) begin
                                    if (phase_reg == PH_ACK) begin
                                        jack_next  = 1'b1;
                                        k_next     = '0;
                                        state_next = ST_J_RD;
                                    end else if (rcnt_reg == CW'(RPL_LEN)) begin
                                        jack_next  = 1'b0;
                                        k_next     = '0;
                                        state_next = ST_J_RD;
                                    end else begin
                                        fail     = 1'b1;
                                        start_rd = 1'b1;
                                    end
                                end
                            end
                        end
                        REQ_RX: begin
                            if ((phase_reg == PH_ACK || phase_reg == PH_REPLY) &&
                                rcnt_reg < rx_limit) begin
                                cmd.op    = OP_RPL_WR;
                                rcnt_next = rcnt_reg + 1'b1;
                                gap_next  = '0;
                            end
                        end
                        REQ_DRAIN: begin
                            if (phase_reg == PH_DRAIN) begin
                                phase_next = PH_ACK;
                                rcnt_next  = '0;
                                gap_next   = '0;
                            end
                        end
                        REQ_CONT: begin
                            if (phase_reg == PH_IDLE) begin
                                if (!link_reg) begin
                                    link_next  = 1'b1;
                                    retry_next = '0;
                                    cmd.op     = OP_SEND_CLR;
                                end
                                page_next = '0;
                                start_wr  = 1'b1;
                            end
                        end
                        REQ_HWR: begin
                            if ({4'd0, s_image_address} < 10'(SEND_SPAN)) begin
                                cmd.op = OP_SEND_WR;
                            end
                        end
                        REQ_HRD: begin
                            haddr_next = s_image_address;
                            state_next = ST_HRD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // frame walk
            ST_EM_RD: begin
                state_next = ST_EM_PUT;
            end
            ST_EM_PUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.kbyte    = em_byte;
                    cmd.src      = em_last ? SRC_SUM : (em_data ? SRC_SEND : SRC_CONST);
                    cmd.sum_clr  = (k_reg == '0);
                    cmd.sum_add  = (k_reg != '0) && !em_last;
                    cmd.out_end  = em_last;
                    if (em_last) begin
                        phase_next = wfrm_reg ? PH_DRAIN : PH_REPLY;
                        rcnt_next  = '0;
                        gap_next   = '0;
                        state_next = ST_WAIT;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_EM_RD;
                    end
                end
            end
            // reply check, each byte read and then checked
            ST_J_RD: begin
                state_next = ST_J_CK;
            end
            ST_J_CK: begin
                cmd.src     = SRC_RPL;
                cmd.chk_clr = (k_reg == '0);
                cmd.sum_clr = (k_reg == '0);
                if (jack_reg) begin
                    cmd.chk_eq = 1'b1;
                    cmd.kbyte  = ack_byte(k_reg[2:0]);
                end else begin
                    cmd.chk_eq  = (k_reg == KW'(0)) || (k_reg == KW'(2)) ||
                                  (k_reg == KW'(5));
                    cmd.kbyte   = (k_reg == KW'(0)) ? CH_STX :
                                  (k_reg == KW'(2)) ? RPL_LEN_BYTE : CH_RESP_OK;
                    cmd.sum_add = (k_reg != '0) && (k_reg < KW'(RPL_LEN - 1));
                    cmd.chk_sum = (k_reg == KW'(RPL_LEN - 1));
                end
                if ((jack_reg && k_reg == KW'(7)) ||
                    (!jack_reg && k_reg == KW'(RPL_LEN - 1))) begin
                    state_next = ST_J_END;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_J_RD;
                end
            end
            ST_J_END: begin
                if (jack_reg) begin
                    if (sts.chk_ok) begin
                        if (pg_inc >= PIW'(SEND_PAGES)) begin
                            page_next = '0;
                            start_rd  = 1'b1;
                        end else begin
                            page_next = pg_inc;
                            start_wr  = 1'b1;
                        end
                    end else begin
                        fail     = 1'b1;
                        start_wr = 1'b1;
                    end
                end else if (sts.chk_ok) begin
                    k_next     = '0;
                    state_next = ST_CP_RD;
                end else begin
                    fail     = 1'b1;
                    start_rd = 1'b1;
                end
            end
            // page copy into the read image
            ST_CP_RD: begin
                state_next = ST_CP_WR;
            end
            ST_CP_WR: begin
                cmd.op = OP_READ_WR;
                if (k_reg == KW'(PAGE_BYTES - 1)) begin
                    if (pg_inc >= PIW'(READ_PAGES)) begin
                        page_next  = '0;
                        phase_next = PH_IDLE;
                        rcnt_next  = '0;
                        gap_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        page_next = pg_inc;
                        start_rd  = 1'b1;
                    end
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_CP_RD;
                end
            end
            ST_HRD: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.src      = SRC_READ;
                    cmd.kind     = KIND_HOST;
                    cmd.out_end  = 1'b1;
                    state_next   = ST_WAIT;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.kind     = KIND_DONE;
                    cmd.out_end  = 1'b1;
                    state_next   = ST_WAIT;
                end
            end
            default: begin
                state_next = ST_WAIT;
            end
        endcase

        // failure count
        if (fail) begin
            if (retry_reg > MAX_RETRY) begin
                link_next = 1'b0;
            end else begin
                retry_next = retry_reg + 1'b1;
            end
        end
        // frame start
        if (start_wr || start_rd) begin
            wfrm_next  = start_wr;
            k_next     = '0;
            state_next = ST_EM_RD;
        end
    end

    assign s_ready   = (state_reg == ST_WAIT);
    assign cfg_ready = 1'b1;

    // state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_WAIT;
            phase_reg     <= PH_IDLE;
            page_reg      <= '0;
            rcnt_reg      <= '0;
            gap_reg       <= '0;
            retry_reg     <= '0;
            link_reg      <= 1'b1;
            k_reg         <= '0;
            wfrm_reg      <= 1'b0;
            jack_reg      <= 1'b0;
            haddr_reg     <= '0;
            gap_ticks_reg <= 16'd100;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            page_reg      <= page_next;
            rcnt_reg      <= rcnt_next;
            gap_reg       <= gap_next;
            retry_reg     <= retry_next;
            link_reg      <= link_next;
            k_reg         <= k_next;
            wfrm_reg      <= wfrm_next;
            jack_reg      <= jack_next;
            haddr_reg     <= haddr_next;
            gap_ticks_reg <= gap_ticks_next;
        end
    end

    // checks
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("output loaded while result still pending");

    a_link_retry: assert property (@(posedge aclk) disable iff (!aresetn)
        !link_reg |-> (retry_reg == MAX_RETRY + 4'd1))
        else $error("link down without exhausted retries");

    a_rcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rcnt_reg <= CW'(RPL_LEN))
        else $error("reply count beyond buffer");

    a_reply_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_J_END && !jack_reg) |-> (rcnt_reg == CW'(RPL_LEN)))
        else $error("read reply judged with wrong length");

endmodule

### hw/rtl/hmi_serial_page_exchange_master_top.sv
// top level of the paged serial exchange master
// host write, rx byte, tick and drain are taken in the wait state; a host read moves
// to a read state that loads the output register once it is free; frames
// (PAGE_BYTES+10 bytes for a write, 10 for a read request) leave byte by byte, each
// byte passing a read state and then loaded when the output is free; a read reply
// is checked, then copied. One item at a time; reset clears control, images read as zero, gap_ticks is 100
module hmi_serial_page_exchange_master_top import hsp_pkg::*; #(
    parameter int PAGE_BYTES = 32,
    parameter int SEND_PAGES = 2,
    parameter int READ_PAGES = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [7:0]  s_data_byte,
    input  logic [5:0]  s_image_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic        m_frame_end,
    output logic        m_link_up,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_gap_ticks
);

    cmd_t cmd;
    sts_t sts;

    // sequencing
    hsp_ctrl #(
        .PAGE_BYTES(PAGE_BYTES),
        .SEND_PAGES(SEND_PAGES),
        .READ_PAGES(READ_PAGES)
    ) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_image_address(s_image_address),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_gap_ticks(cfg_gap_ticks),
        .cmd(cmd),
        .sts(sts)
    );

    // storage and output
    hsp_dp #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_dp (
        .aclk(aclk),
        .aresetn(aresetn),
        .cmd(cmd),
        .sts(sts),
        .s_data_byte(s_data_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_kind(m_out_kind),
        .m_out_byte(m_out_byte),
        .m_frame_end(m_frame_end),
        .m_link_up(m_link_up)
    );

endmodule

### verif/hsp_tb_pkg.sv
// request codes and the good acknowledgement shared by the testbench files
package hsp_tb_pkg;

    // input request codes
    typedef enum logic [2:0] {
        REQ_TICK,
        REQ_RX_BYTE,
        REQ_TX_DRAINED,
        REQ_CONTINUE,
        REQ_HOST_WRITE,
        REQ_HOST_READ,
        REQ_SPARE6,
        REQ_SPARE7
    } req_code_t;

    // acknowledgement the panel gives to a page write
    localparam logic [7:0] ACK_GOOD [8] = '{8'h02, 8'h00, 8'h03, 8'h57, 8'h57, 8'h00, 8'h03,
        8'hB4};

endpackage

### verif/exchange_checker.sv
// predicts the exchange master's results and checks every result transfer
module exchange_checker import hsp_pkg::*; import hsp_tb_pkg::*; #(
    parameter int PAGE_BYTES = 32,
    parameter int SEND_PAGES = 2,
    parameter int READ_PAGES = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [7:0]  s_data_byte,
    input  logic [5:0]  s_image_address,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_out_kind,
    input  logic [7:0]  m_out_byte,
    input  logic        m_frame_end,
    input  logic        m_link_up,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_gap_ticks,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPLY_LEN = PAGE_BYTES + 8;

    typedef enum logic [1:0] {ST_IDLE, ST_DRAIN, ST_ACK, ST_REPLY} stage_t;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic       fend;
        logic       link;
    } result_t;

    result_t     expected_q[$];
    logic [15:0] gap_ticks;
    stage_t      stage;
    int          page;
    logic [7:0]  reply_buf [REPLY_LEN];
    int          reply_cnt;
    logic [15:0] gap_cnt;
    logic [7:0]  send_img [64];
    logic [7:0]  read_img [64];
    int          retries;
    logic        link;

    // queue one expected result
    task automatic push_result(input logic [1:0] kind, input logic [7:0] data, input logic fend);
        expected_q.push_back('{kind, data, fend, link});
    endtask

    task automatic enter(input stage_t st);
        stage = st;
        reply_cnt = 0;
        gap_cnt = '0;
    endtask

    task automatic count_failure();
        if (retries > 10) link = 1'b0;
        else retries++;
    endtask

    // write frame for the current page
    task automatic emit_write_frame();
        logic [7:0] hdr [8];
        logic [7:0] sum;
        logic [7:0] b;
        hdr = '{CH_STX, CH_STATION, 8'(PAGE_BYTES + 5), CH_W, CH_W,
                8'(page * PAGE_BYTES / 2), ADDR_HI_WR, 8'(PAGE_BYTES / 2)};
        sum = '0;
        for (int i = 0; i < 8; i++) begin
            if (i > 0) sum += hdr[i];
            push_result(KIND_TX, hdr[i], 1'b0);
        end
        for (int i = 0; i < PAGE_BYTES; i++) begin
            b = send_img[6'(page * PAGE_BYTES + i)];
            sum += b;
            push_result(KIND_TX, b, 1'b0);
        end
        sum += CH_ETX;
        push_result(KIND_TX, CH_ETX, 1'b0);
        push_result(KIND_TX, sum, 1'b1);
        enter(ST_DRAIN);
    endtask

    // read request for the current page
    task automatic emit_read_request();
        logic [7:0] f [10];
        logic [7:0] sum;
        f[0] = CH_STX; f[1] = CH_STATION; f[2] = RD_REQ_LEN; f[3] = CH_R; f[4] = CH_W;
        f[5] = 8'(page * PAGE_BYTES / 2); f[6] = ADDR_HI_RD; f[7] = 8'(PAGE_BYTES / 2);
        f[8] = CH_ETX;
        sum = '0;
        for (int i = 1; i < 9; i++) sum += f[i];
        f[9] = sum;
        for (int i = 0; i < 10; i++) push_result(KIND_TX, f[i], i == 9);
        enter(ST_REPLY);
    endtask

    task automatic judge_ack();
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 8; i++) if (reply_buf[i] !== ACK_GOOD[i]) ok = 1'b0;
        if (ok) begin
            page++;
            if (page >= SEND_PAGES) begin
                page = 0;
                emit_read_request();
            end else begin
                emit_write_frame();
            end
        end else begin
            count_failure();
            emit_write_frame();
        end
    endtask

    task automatic judge_reply();
        logic [7:0] sum;
        if (reply_cnt == REPLY_LEN && reply_buf[0] == CH_STX &&
            reply_buf[2] == 8'(PAGE_BYTES + 3) && reply_buf[5] == CH_RESP_OK) begin
            sum = '0;
            for (int i = 1; i <= PAGE_BYTES + 6; i++) sum += reply_buf[i];
            if (sum == reply_buf[PAGE_BYTES + 7]) begin
                for (int i = 0; i < PAGE_BYTES; i++)
                    read_img[6'(page * PAGE_BYTES + i)] = reply_buf[i + 6];
                page++;
                if (page >= READ_PAGES) begin
                    page = 0;
                    enter(ST_IDLE);
                    push_result(KIND_DONE, 8'h00, 1'b1);
                end else begin
                    emit_read_request();
                end
                return;
            end
        end
        count_failure();
        emit_read_request();
    endtask

    // one accepted request
    task automatic apply_request(input logic [2:0] req, input logic [7:0] data,
                                 input logic [5:0] addr);
        int limit;
        case (req_code_t'(req))
            REQ_TICK: begin
                if (stage == ST_ACK || stage == ST_REPLY) begin
                    if (gap_cnt != 16'hFFFF) gap_cnt++;
                    if (gap_cnt >= gap_ticks) begin
                        if (stage == ST_ACK) judge_ack();
                        else judge_reply();
                    end
                end
            end
            REQ_RX_BYTE: begin
                limit = (stage == ST_ACK) ? 10 : REPLY_LEN;
                if ((stage == ST_ACK || stage == ST_REPLY) && reply_cnt < limit) begin
                    reply_buf[reply_cnt] = data;
                    reply_cnt++;
                    gap_cnt = '0;
                end
            end
            REQ_TX_DRAINED: begin
                if (stage == ST_DRAIN) enter(ST_ACK);
            end
            REQ_CONTINUE: begin
                if (stage == ST_IDLE) begin
                    if (!link) begin
                        link = 1'b1;
                        retries = 0;
                        foreach (send_img[i]) send_img[i] = '0;
                    end
                    page = 0;
                    emit_write_frame();
                end
            end
            REQ_HOST_WRITE: begin
                if (addr < PAGE_BYTES * SEND_PAGES) send_img[addr] = data;
            end
            REQ_HOST_READ: push_result(KIND_HOST, read_img[addr], 1'b1);
            default: ;
        endcase
    endtask

    // compare one result transfer with the oldest expectation
    task automatic check_result();
        result_t want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result kind %0d byte %h", $realtime, m_out_kind,
                     m_out_byte);
            fail_count++;
            return;
        end
        want = expected_q.pop_front();
        if (m_out_kind !== want.kind) begin
            $display("%0t: out_kind expected %0d actual %0d", $realtime, want.kind, m_out_kind);
            fail_count++;
        end
        if (m_out_byte !== want.data) begin
            $display("%0t: out_byte expected %h actual %h", $realtime, want.data, m_out_byte);
            fail_count++;
        end
        if (m_frame_end !== want.fend) begin
            $display("%0t: frame_end expected %b actual %b", $realtime, want.fend,
                     m_frame_end);
            fail_count++;
        end
        if (m_link_up !== want.link) begin
            $display("%0t: link_up expected %b actual %b", $realtime, want.link, m_link_up);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
    end

    // model state follows every transfer on the three channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            gap_ticks = 16'd100;
            page = 0;
            enter(ST_IDLE);
            foreach (reply_buf[i]) reply_buf[i] = '0;
            foreach (send_img[i]) send_img[i] = '0;
            foreach (read_img[i]) read_img[i] = '0;
            retries = 0;
            link = 1'b1;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) gap_ticks = cfg_gap_ticks;
            if (s_valid && s_ready) apply_request(s_req_type, s_data_byte, s_image_address);
            if (m_valid && m_ready) check_result();
        end
        pending <= expected_q.size();
    end

endmodule

### verif/tb.sv
// stimulus and verdict for the paged serial exchange master
module tb import hsp_pkg::*; import hsp_tb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_BYTES = 32;
    localparam int SEND_PAGES = 2;
    localparam int READ_PAGES = 2;
    localparam int SETTLE = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_req_type = '0;
    logic [7:0]  s_data_byte = '0;
    logic [5:0]  s_image_address = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_out_kind;
    logic [7:0]  m_out_byte;
    logic        m_frame_end;
    logic        m_link_up;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_gap_ticks = '0;
    int          fail_count;
    int          pending;
    int          cur_gap = 100;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          rx_hold = 0;

    hmi_serial_page_exchange_master_top #(
        .PAGE_BYTES(PAGE_BYTES), .SEND_PAGES(SEND_PAGES), .READ_PAGES(READ_PAGES)
    ) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_data_byte(s_data_byte), .s_image_address(s_image_address),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_kind(m_out_kind),
        .m_out_byte(m_out_byte), .m_frame_end(m_frame_end), .m_link_up(m_link_up),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_gap_ticks(cfg_gap_ticks)
    );

    exchange_checker #(
        .PAGE_BYTES(PAGE_BYTES), .SEND_PAGES(SEND_PAGES), .READ_PAGES(READ_PAGES)
    ) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_data_byte(s_data_byte), .s_image_address(s_image_address),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_kind(m_out_kind),
        .m_out_byte(m_out_byte), .m_frame_end(m_frame_end), .m_link_up(m_link_up),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_gap_ticks(cfg_gap_ticks),
        .fail_count(fail_count), .pending(pending)
    );

    always #2 aclk = ~aclk;

    // result side withholds ready at random after each transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                rx_hold = rx_steady ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_ready <= (rx_hold == 0);
        end
    end

    // run limit
    initial begin
        #200us;
        $display("tb: failure");
        $finish;
    end

    // one request transfer, preceded by a random gap
    task automatic send_item(input logic [2:0] req, input logic [7:0] data,
                             input logic [5:0] addr);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_data_byte <= data;
        s_image_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
    endtask

    // wait until every result is out and the block has settled
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_gap(input logic [15:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_gap_ticks <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_gap = value;
    endtask

    task automatic send_ticks();
        repeat ((cur_gap == 0) ? 1 : cur_gap) send_item(REQ_TICK, 8'($urandom), 6'($urandom));
    endtask

    // drained notice and an acknowledgement, spoiled in one byte when not good
    task automatic send_ack(input bit good);
        logic [7:0] ack [10];
        int len;
        send_item(REQ_TX_DRAINED, 8'($urandom), 6'($urandom));
        for (int i = 0; i < 10; i++) ack[i] = (i < 8) ? ACK_GOOD[i] : 8'($urandom);
        if (!good) ack[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 10) : 8;
        for (int i = 0; i < len; i++) send_item(REQ_RX_BYTE, ack[i], 6'($urandom));
    endtask

    // well formed read reply, sometimes with one surplus byte
    task automatic send_reply();
        logic [7:0] rp [PAGE_BYTES + 9];
        logic [7:0] sum;
        int len;
        rp[0] = CH_STX;
        rp[1] = 8'($urandom);
        rp[2] = 8'(PAGE_BYTES + 3);
        rp[3] = 8'($urandom);
        rp[4] = 8'($urandom);
        rp[5] = CH_RESP_OK;
        for (int i = 6; i < PAGE_BYTES + 7; i++) rp[i] = 8'($urandom);
        sum = '0;
        for (int i = 1; i <= PAGE_BYTES + 6; i++) sum += rp[i];
        rp[PAGE_BYTES + 7] = sum;
        rp[PAGE_BYTES + 8] = 8'($urandom);
        len = ($urandom_range(0, 4) == 0) ? PAGE_BYTES + 9 : PAGE_BYTES + 8;
        for (int i = 0; i < len; i++) send_item(REQ_RX_BYTE, rp[i], 6'($urandom));
    endtask

    // requests that must leave an idle block alone, plus host traffic
    task automatic send_noise(input int count);
        logic [2:0] req;
        repeat (count) begin
            do req = 3'($urandom); while (req == REQ_CONTINUE);
            send_item(req, 8'($urandom), 6'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: image extremes and ignored codes on an idle block
        write_gap(16'd1);
        send_item(REQ_HOST_WRITE, 8'hFF, 6'h00);
        send_item(REQ_HOST_WRITE, 8'h00, 6'h3F);
        send_item(REQ_HOST_WRITE, 8'h5A, 6'h20);
        send_item(REQ_HOST_READ, 8'h00, 6'h3F);
        send_item(REQ_SPARE6, 8'hFF, 6'h3F);
        send_item(REQ_SPARE7, 8'h00, 6'h00);
        send_item(REQ_TICK, 8'hFF, 6'h3F);
        send_item(REQ_RX_BYTE, 8'hFF, 6'h3F);
        send_item(REQ_TX_DRAINED, 8'h00, 6'h00);

        // first page gets a spoiled ack and is written again
        send_item(REQ_CONTINUE, 8'($urandom), 6'($urandom));
        send_ack(1'b0);
        send_ticks();
        send_ack(1'b1);
        send_ticks();

        // second page: a long gap holds the judgement, then it is shortened
        send_ack(1'b1);
        write_gap(16'hFFFF);
        repeat (2) send_item(REQ_TICK, 8'hFF, 6'h3F);
        write_gap(16'd2);
        send_item(REQ_TICK, 8'h00, 6'h00);

        // zero gap: empty replies fail at once until the link goes down
        write_gap(16'd0);
        repeat (11) send_item(REQ_TICK, 8'($urandom), 6'($urandom));

        // good replies for every read page
        write_gap(16'd1);
        for (int p = 0; p < READ_PAGES; p++) begin
            send_reply();
            send_ticks();
        end
        send_item(REQ_HOST_READ, 8'h00, 6'h00);
        send_item(REQ_HOST_READ, 8'h00, 6'h3F);
        send_noise(3);

        // continue brings the link back up with a cleared send image
        send_item(REQ_CONTINUE, 8'($urandom), 6'($urandom));

        drain_results();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/hsp_pkg.sv
hw/rtl/hsp_dp.sv
hw/rtl/hsp_ctrl.sv
hw/rtl/hmi_serial_page_exchange_master_top.sv
verif/hsp_tb_pkg.sv
verif/exchange_checker.sv
verif/tb.sv
